// ----- design/oaht_pkg.sv -----
// Shared types and constants for the open-addressing hash table.
// No dependencies.
package oaht_pkg;

    localparam int ACT_W  = 2;
    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int VAL_W  = 64;
    localparam int LIM_W  = 6;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;

    localparam logic [ACT_W-1:0] ACT_GET = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEL = 2'd2;

    localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [ST_W-1:0] ST_LIVE  = 2'd1;
    localparam logic [ST_W-1:0] ST_TOMB  = 2'd2;

    localparam logic [LIM_W-1:0] LIM_RESET = 6'd48;

    typedef struct packed {
        logic [ST_W-1:0]  st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic probe_start;
        logic probe_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic skip;
        logic probe_done;
        logic out_busy;
    } sts_t;

endpackage

// ----- design/oaht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oaht_ram #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/oaht_mod.sv -----
// Reduces the key hash modulo the slot count: a mask for a power of two,
// otherwise restoring reduction eight bits per cycle. Depends on oaht_pkg.
module oaht_mod #(
    parameter int SLOTS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              hash,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] remainder
);
    import oaht_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    logic          done_reg, done_next;
    logic [IW-1:0] rem_reg, rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    generate
        if (IS_POW2)
        begin : g_mask
            always_comb
            begin
                done_next = start;
                rem_next  = start ? hash[IW-1:0] : rem_reg;
            end
        end
        else
        begin : g_div
            localparam int STEP  = 8;
            localparam int NSTEP = HASH_W / STEP;
            localparam int CW    = $clog2(NSTEP);
            localparam logic [IW:0] MODULUS = (IW+1)'(SLOTS);

            logic              busy_reg, busy_next;
            logic [CW-1:0]     cnt_reg, cnt_next;
            logic [HASH_W-1:0] dvd_reg, dvd_next;
            logic [IW-1:0]     step_rem;
            logic [IW-1:0]     r;
            logic [IW:0]       t;

            always_comb
            begin
                r = rem_reg;
                t = '0;
                for (int i = 0; i < STEP; i++)
                begin
                    t = {r, dvd_reg[HASH_W-1-i]};
                    if (t >= MODULUS)
                    begin
                        t = t - MODULUS;
                    end
                    r = t[IW-1:0];
                end
                step_rem = r;
            end

            always_comb
            begin
                busy_next = busy_reg;
                cnt_next  = cnt_reg;
                dvd_next  = dvd_reg;
                rem_next  = rem_reg;
                done_next = 1'b0;
                if (start)
                begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    dvd_next  = hash;
                    rem_next  = '0;
                end
                else if (busy_reg)
                begin
                    rem_next = step_rem;
                    dvd_next = dvd_reg << STEP;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(NSTEP - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    cnt_reg  <= cnt_next;
                end
            end

            always_ff @(posedge clk)
            begin
                dvd_reg <= dvd_next;
            end
        end
    endgenerate

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/oaht_ctrl.sv -----
// Request sequencer: clearing pass, hash, probe walk, finish.
// Depends on oaht_pkg.
module oaht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  oaht_pkg::sts_t sts,
    output oaht_pkg::cmd_t cmd
);
    import oaht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                priority if (sts.skip)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.mod_done)
                begin
                    state_next = S_PROBE;
                end
                else
                begin
                    state_next = S_HASH;
                end
            end
            S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_HASH:
            begin
                cmd.probe_start = !sts.skip && sts.mod_done;
            end
            S_PROBE:
            begin
                cmd.probe_step = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/oaht_dp.sv -----
// Datapath: slot RAM, hash reduction, probe registers, counters and result word.
// Depends on oaht_pkg, oaht_ram, oaht_mod.
module oaht_dp #(
    parameter int SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  oaht_pkg::cmd_t                  cmd,
    output oaht_pkg::sts_t                  sts,
    input  logic [oaht_pkg::ACT_W-1:0]      action,
    input  logic [oaht_pkg::KEY_W-1:0]      key_id,
    input  logic [oaht_pkg::HASH_W-1:0]     key_hash,
    input  logic [oaht_pkg::VAL_W-1:0]      write_value,
    input  logic                            cfg_we,
    input  logic [oaht_pkg::LIM_W-1:0]      cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [oaht_pkg::VAL_W-1:0]      read_value,
    output logic                            full_res
);
    import oaht_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    // request
    logic [ACT_W-1:0] act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // control and counters
    logic [LIM_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IW-1:0]    clr_reg, clr_next;

    // probe
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] last_idx_reg, last_idx_next;
    logic [IW-1:0] n_reg, n_next;
    logic          pend_reg, pend_next;
    logic          have_tomb_reg, have_tomb_next;
    logic [IW-1:0] tomb_reg, tomb_next;
    logic [IW-1:0] where_reg, where_next;
    logic          live_reg, live_next;
    logic          fail_reg, fail_next;
    logic          claim_reg, claim_next;

    // result word
    logic             ov_reg, ov_next;
    logic             hit_reg, hit_next;
    logic [VAL_W-1:0] rval_reg, rval_next;
    logic             full_reg, full_next;

    logic          mod_done;
    logic [IW-1:0] mod_rem;
    slot_t         rd;
    slot_t         wdata;
    logic          we;
    logic [IW-1:0] waddr;
    logic          rd_issue;
    logic          is_live, is_tomb, hit_now, empty_now, last_now, end_now;
    logic          over;
    logic          res_hit, res_full, res_we, res_inc;
    logic [VAL_W-1:0] res_val;
    logic [ST_W-1:0]  res_st;
    logic [IW-1:0]    idx_inc;

    oaht_mod #(
        .SLOTS(SLOTS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load_req),
        .hash     (key_hash),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    oaht_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (rd_issue),
        .raddr(idx_reg),
        .rdata(rd)
    );

    // slot evaluation on the word read in the previous cycle
    assign is_live   = (rd.st == ST_LIVE);
    assign is_tomb   = (rd.st == ST_TOMB);
    assign hit_now   = is_live && (rd.key == key_reg);
    assign empty_now = !is_live && !is_tomb;
    assign last_now  = (n_reg == LAST_SLOT);
    assign end_now   = pend_reg && (hit_now || empty_now || last_now);
    assign rd_issue  = cmd.probe_step && !end_now;
    assign idx_inc   = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;

    assign over = ({1'b0, used_reg} + (CNT_W+1)'(1)) > (CNT_W+1)'(limit_reg);

    always_comb
    begin
        sts.clear_last = (clr_reg == LAST_SLOT);
        sts.mod_done   = mod_done;
        sts.probe_done = cmd.probe_step && end_now;
        sts.out_busy   = ov_reg && !out_ready;
        unique case (act_reg)
            ACT_GET, ACT_DEL: sts.skip = (used_reg == '0);
            ACT_SET:          sts.skip = over;
            default:          sts.skip = 1'b1;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        have_tomb_next = have_tomb_reg;
        tomb_next      = tomb_reg;
        where_next     = where_reg;
        live_next      = live_reg;
        fail_next      = fail_reg;
        claim_next     = claim_reg;
        if (cmd.load_req)
        begin
            live_next  = 1'b0;
            fail_next  = 1'b0;
            claim_next = 1'b0;
        end
        if (cmd.probe_start)
        begin
            idx_next       = mod_rem;
            n_next         = '0;
            pend_next      = 1'b0;
            have_tomb_next = 1'b0;
        end
        if (cmd.probe_step)
        begin
            if (rd_issue)
            begin
                last_idx_next = idx_reg;
                idx_next      = idx_inc;
                pend_next     = 1'b1;
            end
            if (pend_reg)
            begin
                n_next = n_reg + 1'b1;
                priority if (hit_now)
                begin
                    where_next = last_idx_reg;
                    live_next  = 1'b1;
                end
                else if (empty_now)
                begin
                    where_next = have_tomb_reg ? tomb_reg : last_idx_reg;
                    claim_next = !have_tomb_reg;
                end
                else if (last_now)
                begin
                    // whole table walked without key or empty slot
                    where_next = have_tomb_reg ? tomb_reg : last_idx_reg;
                    fail_next  = !have_tomb_reg && !is_tomb;
                end
                else
                begin
                    if (is_tomb && !have_tomb_reg)
                    begin
                        have_tomb_next = 1'b1;
                        tomb_next      = last_idx_reg;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res_hit  = 1'b0;
        res_val  = '0;
        res_full = 1'b0;
        res_we   = 1'b0;
        res_inc  = 1'b0;
        res_st   = ST_LIVE;
        unique case (act_reg)
            ACT_GET:
            begin
                res_hit = live_reg;
                res_val = live_reg ? rd.val : '0;
            end
            ACT_SET:
            begin
                res_full = over || fail_reg;
                res_hit  = !res_full && !live_reg;
                res_we   = !res_full;
                res_inc  = !res_full && !live_reg && claim_reg;
            end
            ACT_DEL:
            begin
                res_hit = live_reg;
                res_we  = live_reg;
                res_st  = ST_TOMB;
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        we    = cmd.clear_step || (cmd.finish && res_we);
        waddr = cmd.clear_step ? clr_reg : where_reg;
        if (cmd.clear_step)
        begin
            wdata = '{st: ST_EMPTY, key: '0, val: '0};
        end
        else
        begin
            wdata = '{st: res_st, key: key_reg, val: val_reg};
        end
    end

    always_comb
    begin
        limit_next = cfg_we ? cfg_data : limit_reg;
        used_next  = (cmd.finish && res_inc) ? used_reg + 1'b1 : used_reg;
        clr_next   = cmd.clear_step ? clr_reg + 1'b1 : clr_reg;
        ov_next    = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
        hit_next   = cmd.finish ? res_hit : hit_reg;
        rval_next  = cmd.finish ? res_val : rval_reg;
        full_next  = cmd.finish ? res_full : full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIM_RESET;
            used_reg      <= '0;
            clr_reg       <= '0;
            ov_reg        <= 1'b0;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            have_tomb_reg <= 1'b0;
            live_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            claim_reg     <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            used_reg      <= used_next;
            clr_reg       <= clr_next;
            ov_reg        <= ov_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            have_tomb_reg <= have_tomb_next;
            live_reg      <= live_next;
            fail_reg      <= fail_next;
            claim_reg     <= claim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            act_reg <= action;
            key_reg <= key_id;
            val_reg <= write_value;
        end
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        tomb_reg     <= tomb_next;
        where_reg    <= where_next;
        hit_reg      <= hit_next;
        rval_reg     <= rval_next;
        full_reg     <= full_next;
    end

    assign out_valid  = ov_reg;
    assign hit        = hit_reg;
    assign read_value = rval_reg;
    assign full_res   = full_reg;

endmodule

// ----- design/open_addressing_hash_table.sv -----
// Open-addressing hash table, linear probing with tombstones; top level.
// Requests are taken one at a time: in_ready is high only while idle, so no request is
// accepted while another is still being hashed, probed or finished.
// The probe walk reads one slot per cycle from the RAM.
// Reset: clearing pass over the slot RAM with in_ready low.
// Depends on oaht_pkg, oaht_ctrl, oaht_dp.
module open_addressing_hash_table #(
    parameter int SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [oaht_pkg::ACT_W-1:0]  action,
    input  logic [oaht_pkg::KEY_W-1:0]  key_id,
    input  logic [oaht_pkg::HASH_W-1:0] key_hash,
    input  logic [oaht_pkg::VAL_W-1:0]  write_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic [oaht_pkg::VAL_W-1:0]  read_value,
    output logic                        full_res,
    input  logic                        cfg_we,
    input  logic [oaht_pkg::LIM_W-1:0]  cfg_data
);
    import oaht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    oaht_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    oaht_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .action     (action),
        .key_id     (key_id),
        .key_hash   (key_hash),
        .write_value(write_value),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value),
        .full_res   (full_res)
    );

endmodule

// ----- design/oaht_checker.sv -----
// Port-level checks for the hash table, bound to the top level.
// Depends on open_addressing_hash_table.
module oaht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [63:0] read_value,
    input logic        full_res
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted while a request is in flight");

    a_value_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit || read_value == 64'd0))
        else $error("read_value non-zero without hit");

    a_full_excludes_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_res |-> !hit)
        else $error("full_res and hit together");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value)
            && $stable(full_res))
        else $error("stalled result word changed");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .read_value(read_value),
    .full_res  (full_res)
);
